// File: hdl/rhsl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhsl_pkg
// Shared widths for the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rhsl_pkg;

    localparam int CHAN_W = 8;   // one color channel
    localparam int HUE_W  = 15;  // hue port
    localparam int FRAC_W = 17;  // saturation and lightness ports

endpackage : rhsl_pkg
`default_nettype wire

// File: hdl/rgb_to_hsl_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// 8-bit RGB pixel to fixed-point hue, saturation and lightness.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                  payload
//  in       in   i_in_valid / o_in_stall    i_red, i_green, i_blue
//  out      out  o_out_valid / i_out_stall  o_hue, o_saturation, o_lightness
//
//  One pixel per cycle sustained while the output is not stalled. QW is
//  max(HUE_FRAC_BITS + 9, FRACTION_BITS + 1), the quotient width of the
//  bit-per-stage dividers. Reset empties the pipeline (valid bits only).
//  A stalled output beat freezes every stage; o_in_stall follows it.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int FRACTION_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire  [rhsl_pkg::CHAN_W-1:0] i_red,
    input  wire  [rhsl_pkg::CHAN_W-1:0] i_green,
    input  wire  [rhsl_pkg::CHAN_W-1:0] i_blue,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [rhsl_pkg::HUE_W-1:0]  o_hue,
    output logic [rhsl_pkg::FRAC_W-1:0] o_saturation,
    output logic [rhsl_pkg::FRAC_W-1:0] o_lightness
);
    import rhsl_pkg::*;

    localparam int HUE_QW  = HUE_FRAC_BITS + 9;
    localparam int FRAC_QW = FRACTION_BITS + 1;
    localparam int QW      = (HUE_QW > FRAC_QW) ? HUE_QW : FRAC_QW;
    localparam int OW      = (QW > FRAC_W) ? QW : FRAC_W;

    logic w_ce;
    logic w_fvalid;
    logic [QW+CHAN_W-1:0] w_hue_num, w_sat_num;
    logic [CHAN_W-1:0]    w_hue_den, w_sat_den;
    logic [FRAC_W-1:0]    w_lig_f;
    logic [QW-1:0]        w_hue_q, w_sat_q;
    logic [OW-1:0]        w_hue_x, w_sat_x;
    logic [QW-1:0]        r_vpipe;
    logic [FRAC_W-1:0]    r_lig_pipe [QW];

    assign w_ce       = !o_out_valid || !i_out_stall;
    assign o_in_stall = !w_ce;

    rhsl_front #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .QW            (QW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ce      (w_ce),
        .i_valid   (i_in_valid),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .o_valid   (w_fvalid),
        .o_hue_num (w_hue_num),
        .o_hue_den (w_hue_den),
        .o_sat_num (w_sat_num),
        .o_sat_den (w_sat_den),
        .o_lig     (w_lig_f)
    );

    rhsl_div #(.QW(QW), .DVW(CHAN_W)) u_div_hue (
        .i_clk      (i_clk),
        .i_ce       (w_ce),
        .i_dividend (w_hue_num),
        .i_divisor  (w_hue_den),
        .o_quotient (w_hue_q)
    );

    rhsl_div #(.QW(QW), .DVW(CHAN_W)) u_div_sat (
        .i_clk      (i_clk),
        .i_ce       (w_ce),
        .i_dividend (w_sat_num),
        .i_divisor  (w_sat_den),
        .o_quotient (w_sat_q)
    );

    // lightness waits alongside the dividers
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_lig_pipe[0] <= w_lig_f;
            for (int k = 1; k < QW; k++) begin
                r_lig_pipe[k] <= r_lig_pipe[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpipe <= '0;
        end else if (w_ce) begin
            r_vpipe <= {r_vpipe[QW-2:0], w_fvalid};
        end
    end

    assign o_out_valid = r_vpipe[QW-1];

    assign w_hue_x = OW'(w_hue_q);
    assign w_sat_x = OW'(w_sat_q);

    assign o_hue        = w_hue_x[HUE_W-1:0];
    assign o_saturation = w_sat_x[FRAC_W-1:0];
    assign o_lightness  = r_lig_pipe[QW-1];

endmodule : rgb_to_hsl_converter
`default_nettype wire

// File: hdl/rhsl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhsl_front
// Two register stages: channel max/min, sector and difference, then the
// dividends and divisors for hue and saturation, and the lightness by a
// reciprocal multiply.
// ----------------------------------------------------------------------------
module rhsl_front #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int FRACTION_BITS = 16,
    parameter int QW            = 17
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_ce,
    input  wire                          i_valid,
    input  wire  [rhsl_pkg::CHAN_W-1:0]  i_red,
    input  wire  [rhsl_pkg::CHAN_W-1:0]  i_green,
    input  wire  [rhsl_pkg::CHAN_W-1:0]  i_blue,
    output logic                         o_valid,
    output logic [QW+rhsl_pkg::CHAN_W-1:0] o_hue_num,
    output logic [rhsl_pkg::CHAN_W-1:0]  o_hue_den,
    output logic [QW+rhsl_pkg::CHAN_W-1:0] o_sat_num,
    output logic [rhsl_pkg::CHAN_W-1:0]  o_sat_den,
    output logic [rhsl_pkg::FRAC_W-1:0]  o_lig
);
    import rhsl_pkg::*;

    localparam int NW = QW + CHAN_W;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    localparam logic [8:0] BASE_RED_WRAP = 9'd360;
    localparam logic [8:0] BASE_GREEN    = 9'd120;
    localparam logic [8:0] BASE_BLUE     = 9'd240;
    localparam logic [8:0] HALF_SPAN     = 9'd255;
    localparam logic [8:0] FULL_SPAN     = 9'd510;

    localparam int LIG_SH = 18;
    localparam int LRW    = FRACTION_BITS + 10;
    localparam logic [LRW-1:0] LIG_RECIP =
        LRW'(((64'd1 << (FRACTION_BITS + LIG_SH)) + 64'(FULL_SPAN) - 64'd1)
             / 64'(FULL_SPAN));

    // stage 1
    logic [CHAN_W-1:0] n_mx, n_mn;
    t_sector           n_sec;
    logic signed [8:0] n_diff;
    logic              n_neg;

    logic              r1_valid;
    logic [CHAN_W-1:0] r1_d;
    logic [8:0]        r1_sum;
    t_sector           r1_sec;
    logic signed [8:0] r1_diff;
    logic              r1_neg;

    always_comb begin
        n_mx = i_red;
        n_mn = i_red;
        if (i_green > n_mx) n_mx = i_green;
        if (i_blue  > n_mx) n_mx = i_blue;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue  < n_mn) n_mn = i_blue;
    end

    always_comb begin
        n_neg = 1'b0;
        priority if (i_red == n_mx) begin
            n_sec  = SEC_RED;
            n_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
            n_neg  = (i_green < i_blue);
        end else if (i_green == n_mx) begin
            n_sec  = SEC_GREEN;
            n_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_sec  = SEC_BLUE;
            n_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_ce) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_d    <= n_mx - n_mn;
            r1_sum  <= {1'b0, n_mx} + {1'b0, n_mn};
            r1_sec  <= n_sec;
            r1_diff <= n_diff;
            r1_neg  <= n_neg;
        end
    end

    // stage 2
    logic [8:0]         w_base;
    logic [16:0]        w_base_d;
    logic signed [18:0] w_t;
    logic [CHAN_W-1:0]  w_den_d;
    logic [CHAN_W-1:0]  w_den_s;
    logic [8:0]         w_wrap;
    logic [LRW+8:0]     w_lig_prod;

    always_comb begin
        unique case (r1_sec)
            SEC_RED:   w_base = r1_neg ? BASE_RED_WRAP : 9'd0;
            SEC_GREEN: w_base = BASE_GREEN;
            SEC_BLUE:  w_base = BASE_BLUE;
            default:   w_base = 9'd0;
        endcase
    end

    // hue in degrees times d; never negative
    assign w_base_d = 17'(w_base) * 17'(r1_d);
    assign w_t      = $signed({2'b00, w_base_d}) + 19'(r1_diff) * 19'sd60;

    assign w_den_d = (r1_d == '0) ? CHAN_W'(1) : r1_d;
    assign w_wrap  = FULL_SPAN - r1_sum;
    assign w_den_s = (r1_d == '0)        ? CHAN_W'(1) :
                     (r1_sum <= HALF_SPAN) ? r1_sum[CHAN_W-1:0] : w_wrap[CHAN_W-1:0];

    // sum * 2^F / 510, exact for every sum up to 510
    assign w_lig_prod = (LRW+9)'(r1_sum) * (LRW+9)'(LIG_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_ce) begin
            o_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_hue_num <= NW'(w_t[16:0]) << HUE_FRAC_BITS;
            o_hue_den <= w_den_d;
            o_sat_num <= NW'(r1_d) << FRACTION_BITS;
            o_sat_den <= w_den_s;
            o_lig     <= FRAC_W'(w_lig_prod >> LIG_SH);
        end
    end

endmodule : rhsl_front
`default_nettype wire

// File: hdl/rhsl_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhsl_div
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// Needs dividend < divisor * 2^QW.
// ----------------------------------------------------------------------------
module rhsl_div #(
    parameter int QW  = 17,
    parameter int DVW = 8
) (
    input  wire                  i_clk,
    input  wire                  i_ce,
    input  wire  [QW+DVW-1:0]    i_dividend,
    input  wire  [DVW-1:0]       i_divisor,
    output logic [QW-1:0]        o_quotient
);
    localparam int RW = QW + DVW;

    logic [RW-1:0]  r_rem [QW-1];
    logic [DVW-1:0] r_div [QW-1];
    logic [QW-1:0]  r_q   [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        localparam int J = QW - 1 - i;

        logic [RW-1:0]  w_rem;
        logic [DVW-1:0] w_div;
        logic [QW-1:0]  w_q;
        logic [RW-1:0]  w_shd;
        logic           w_ge;
        logic [QW-1:0]  n_q;

        if (i == 0) begin : g_first
            assign w_rem = i_dividend;
            assign w_div = i_divisor;
            assign w_q   = '0;
        end else begin : g_next
            assign w_rem = r_rem[i-1];
            assign w_div = r_div[i-1];
            assign w_q   = r_q[i-1];
        end

        assign w_shd = RW'(w_div) << J;
        assign w_ge  = (w_rem >= w_shd);
        assign n_q   = w_q | (QW'(w_ge) << J);

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_q[i] <= n_q;
            end
        end

        if (i < QW - 1) begin : g_carry
            logic [RW-1:0] n_rem;

            assign n_rem = w_ge ? (w_rem - w_shd) : w_rem;

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[i] <= n_rem;
                    r_div[i] <= w_div;
                end
            end
        end
    end

    assign o_quotient = r_q[QW-1];

endmodule : rhsl_div
`default_nettype wire

// File: hdl/rhsl_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhsl_chk
// Port-level checks for the RGB to HSL converter.
// ----------------------------------------------------------------------------
module rhsl_chk (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_in_valid,
    input wire                         o_in_stall,
    input wire  [rhsl_pkg::CHAN_W-1:0] i_red,
    input wire  [rhsl_pkg::CHAN_W-1:0] i_green,
    input wire  [rhsl_pkg::CHAN_W-1:0] i_blue,
    input wire                         o_out_valid,
    input wire                         i_out_stall,
    input wire  [rhsl_pkg::HUE_W-1:0]  o_hue,
    input wire  [rhsl_pkg::FRAC_W-1:0] o_saturation,
    input wire  [rhsl_pkg::FRAC_W-1:0] o_lightness
);
    // a stalled output beat backs up the whole pipe
    a_stall_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("output stall not seen at input");

    // an empty output register never blocks the input
    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_beat_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hue)
            && $stable(o_saturation) && $stable(o_lightness))
        else $error("stalled output beat changed");

    a_in_beat_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_red)
            && $stable(i_green) && $stable(i_blue))
        else $error("stalled input beat changed");

endmodule : rhsl_chk

bind rgb_to_hsl_converter rhsl_chk u_rhsl_chk (.*);
`default_nettype wire
